FILE: sv/limit_order_book_macros.svh
// assertion macros of the order book checker
`ifndef LIMIT_ORDER_BOOK_MACROS_SVH
`define LIMIT_ORDER_BOOK_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LOB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lob check failed");

// antecedent implies consequent in the next cycle
`define LOB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lob check failed");

`endif

FILE: sv/lob_pkg.sv
// types, constants and helpers of the limit order book
package lob_pkg;

   localparam int ORDER_SLOTS = 256;
   localparam int SLOT_W      = $clog2(ORDER_SLOTS);
   localparam int PRICE_TICKS = 1024;
   localparam int PRICE_W     = $clog2(PRICE_TICKS);
   localparam int LVL_W       = PRICE_W + 1;
   localparam int LEVELS      = 2 * PRICE_TICKS;
   localparam int MAX_DEPTH   = 64;
   localparam int DEPTH_W     = 7;
   localparam int CNT_W       = SLOT_W + 1;
   localparam int ID_W        = 64;
   localparam int QTY_W       = 32;
   localparam int SUM_W       = 40;
   localparam int ARR_W       = 32;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef enum logic [2:0] {
      MODE_ADD    = 3'd0,
      MODE_CANCEL = 3'd1,
      MODE_REMOVE = 3'd2,
      MODE_CLEAR  = 3'd3,
      MODE_BEST   = 3'd4,
      MODE_DEPTH  = 3'd5,
      MODE_VOLUME = 3'd6,
      MODE_NONE   = 3'd7
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLR, ST_IDLE, ST_FREE, ST_SRD, ST_SCHK, ST_LRD, ST_LCHK, ST_DFIN, ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               bid_valid;
      logic [PRICE_W-1:0] top_bid;
      logic               ask_valid;
      logic [PRICE_W-1:0] top_ask;
      logic               mid_valid;
      logic [PRICE_W:0]   mid_half_ticks;
      logic               level_valid;
      logic [PRICE_W-1:0] level_price;
      logic [SUM_W-1:0]   level_qty;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic               side;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
      logic [ARR_W-1:0]   arrival;
   } slot_type;

   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic [SUM_W-1:0] sum;
   } lvl_type;

   // single result that carries only a status
   function automatic rsp_type rsp_plain(input logic [1:0] status);
      rsp_type r;
      r        = '0;
      r.status = status;
      r.last   = 1'b1;
      return r;
   endfunction

   // result that carries one level
   function automatic rsp_type rsp_level(input logic [PRICE_W-1:0] price,
                                         input logic [SUM_W-1:0] qty,
                                         input logic last);
      rsp_type r;
      r             = '0;
      r.level_valid = 1'b1;
      r.level_price = price;
      r.level_qty   = qty;
      r.last        = last;
      return r;
   endfunction

endpackage

FILE: sv/limit_order_book.sv
// limit order book: order slot store, per-level totals and the sequencer that walks them
// add: free-slot search, then a level refresh walk over every slot
// cancel: a search over every slot plus a refresh walk; remove level: one walk over every slot
// clear: one level-memory write per cycle over all levels; best/mid: a bid scan, then an ask scan
// depth: a tick scan plus one response per reported level; volume: one level read
// one transaction in flight at a time; reset: synchronous, then a sweep of all levels
module limit_order_book (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_mode,
   input  logic [63:0]          req_order_id,
   input  logic                 req_side,
   input  logic [9:0]           req_price_tick,
   input  logic [31:0]          req_quantity,
   input  logic [6:0]           req_max_levels,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic                 rsp_bid_valid,
   output logic [9:0]           rsp_top_bid,
   output logic                 rsp_ask_valid,
   output logic [9:0]           rsp_top_ask,
   output logic                 rsp_mid_valid,
   output logic [10:0]          rsp_mid_half_ticks,
   output logic                 rsp_level_valid,
   output logic [9:0]           rsp_level_price,
   output logic [39:0]          rsp_level_qty,
   output logic                 rsp_last
);

   // sequencer state
   lob_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic boot_ff, boot_in;

   // latched transaction
   lob_pkg::mode_type mode_ff, mode_in;
   logic [lob_pkg::ID_W-1:0]    id_ff, id_in;
   logic                        side_ff, side_in;
   logic [lob_pkg::PRICE_W-1:0] price_ff, price_in;
   logic [lob_pkg::QTY_W-1:0]   qty_ff, qty_in;
   logic [lob_pkg::DEPTH_W-1:0] lim_ff, lim_in;

   // walk counters and accumulators
   logic [lob_pkg::SLOT_W-1:0]  sidx_ff, sidx_in;
   logic [lob_pkg::LVL_W-1:0]   lidx_ff, lidx_in;
   logic                        refresh_ff, refresh_in;
   logic                        found_ff, found_in;
   logic [lob_pkg::SLOT_W-1:0]  best_ff, best_in;
   logic [lob_pkg::ARR_W-1:0]   best_age_ff, best_age_in;
   logic [lob_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [lob_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [lob_pkg::DEPTH_W-1:0] n_ff, n_in;
   logic                        pend_ff, pend_in;
   logic [lob_pkg::PRICE_W-1:0] pend_price_ff, pend_price_in;
   logic [lob_pkg::SUM_W-1:0]   pend_qty_ff, pend_qty_in;
   logic                        phase_ff, phase_in;
   logic                        bid_v_ff, bid_v_in;
   logic [lob_pkg::PRICE_W-1:0] bid_ff, bid_in;
   logic [lob_pkg::ARR_W-1:0]   arrival_ff, arrival_in;

   // staged result and output register
   lob_pkg::rsp_type res_ff, res_in, rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   // order slot store: valid bits in flops, payload in memory
   logic [lob_pkg::ORDER_SLOTS-1:0] slot_valid_ff;
   lob_pkg::slot_type slot_mem [lob_pkg::ORDER_SLOTS];
   lob_pkg::slot_type slot_rd_ff, slot_wdata;
   logic slot_we;

   // per-level totals memory, addressed by {side, price}
   lob_pkg::lvl_type lvl_mem [lob_pkg::LEVELS];
   lob_pkg::lvl_type lvl_rd_ff, lvl_wdata;
   logic lvl_we;
   logic [lob_pkg::LVL_W-1:0] lvl_waddr, lvl_raddr;

   // valid-bit controls
   logic v_set, v_clr, v_clr_all;
   logic [lob_pkg::SLOT_W-1:0] v_clr_idx;

   // shared datapath of the walks
   logic match, id_match, better, cand_found;
   logic [lob_pkg::SLOT_W-1:0] cand_best;
   logic [lob_pkg::ARR_W-1:0]  age;
   logic [lob_pkg::SUM_W:0]    sum_wide;
   logic [lob_pkg::SUM_W-1:0]  sum_acc;
   logic [lob_pkg::CNT_W-1:0]  cnt_acc;
   logic sidx_last, lidx_last, sweep_last, out_free;
   logic scan_side;
   logic [lob_pkg::PRICE_W-1:0] scan_price;
   logic lvl_hit, lvl_qual;
   logic [lob_pkg::DEPTH_W-1:0] n_new;
   logic [lob_pkg::DEPTH_W-1:0] lim_calc;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sidx_last  = (sidx_ff == lob_pkg::SLOT_W'(lob_pkg::ORDER_SLOTS - 1));
   assign lidx_last  = &lidx_ff[lob_pkg::PRICE_W-1:0];
   assign sweep_last = &lidx_ff;

   // slot compare: side and price match, then id for cancel
   assign match    = slot_valid_ff[sidx_ff] && (slot_rd_ff.side == side_ff)
                     && (slot_rd_ff.price == price_ff);
   assign id_match = match && (slot_rd_ff.id == id_ff);
   assign age      = arrival_ff - slot_rd_ff.arrival;
   assign better   = id_match && (!found_ff || (age > best_age_ff));
   assign cand_found = found_ff || better;
   assign cand_best  = better ? sidx_ff : best_ff;

   // saturating level sum
   assign sum_wide = {1'b0, sum_ff} + {{(lob_pkg::SUM_W + 1 - lob_pkg::QTY_W){1'b0}},
                                        slot_rd_ff.qty};
   assign sum_acc  = match ? (sum_wide[lob_pkg::SUM_W] ? '1 : sum_wide[lob_pkg::SUM_W-1:0])
                           : sum_ff;
   assign cnt_acc  = match ? cnt_ff + 1'b1 : cnt_ff;

   // price of the level being scanned: bids high to low, asks low to high
   always_comb begin
      scan_side = side_ff;
      if (mode_ff == lob_pkg::MODE_BEST) begin
         scan_side = phase_ff;
      end
      if (mode_ff == lob_pkg::MODE_VOLUME) begin
         scan_price = price_ff;
      end else if (scan_side) begin
         scan_price = lidx_ff[lob_pkg::PRICE_W-1:0];
      end else begin
         scan_price = ~lidx_ff[lob_pkg::PRICE_W-1:0];
      end
   end

   assign lvl_raddr = {scan_side, scan_price};
   assign lvl_hit   = (lvl_rd_ff.cnt != '0);
   assign lvl_qual  = lvl_hit && (lvl_rd_ff.sum != '0);
   assign n_new     = n_ff + 1'b1;
   assign lim_calc  = (req_max_levels > lob_pkg::DEPTH_W'(lob_pkg::MAX_DEPTH))
                      ? lob_pkg::DEPTH_W'(lob_pkg::MAX_DEPTH) : req_max_levels;

   // next state
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      boot_in       = boot_ff;
      mode_in       = mode_ff;
      id_in         = id_ff;
      side_in       = side_ff;
      price_in      = price_ff;
      qty_in        = qty_ff;
      lim_in        = lim_ff;
      sidx_in       = sidx_ff;
      lidx_in       = lidx_ff;
      refresh_in    = refresh_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_age_in   = best_age_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      n_in          = n_ff;
      pend_in       = pend_ff;
      pend_price_in = pend_price_ff;
      pend_qty_in   = pend_qty_ff;
      phase_in      = phase_ff;
      bid_v_in      = bid_v_ff;
      bid_in        = bid_ff;
      arrival_in    = arrival_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (state_ff)
         lob_pkg::ST_CLR: begin
            lidx_in = lidx_ff + 1'b1;
            if (sweep_last) begin
               boot_in = 1'b0;
               if (boot_ff) begin
                  state_in = lob_pkg::ST_IDLE;
               end else begin
                  res_in   = lob_pkg::rsp_plain(lob_pkg::STATUS_OK);
                  ret_in   = lob_pkg::ST_IDLE;
                  state_in = lob_pkg::ST_EMIT;
               end
            end
         end
         lob_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in    = lob_pkg::mode_type'(req_mode);
               id_in      = req_order_id;
               side_in    = req_side;
               price_in   = req_price_tick[lob_pkg::PRICE_W-1:0];
               qty_in     = req_quantity;
               lim_in     = lim_calc;
               sidx_in    = '0;
               lidx_in    = '0;
               refresh_in = 1'b0;
               found_in   = 1'b0;
               cnt_in     = '0;
               sum_in     = '0;
               n_in       = '0;
               pend_in    = 1'b0;
               phase_in   = 1'b0;
               ret_in     = lob_pkg::ST_IDLE;
               case (lob_pkg::mode_type'(req_mode))
                  lob_pkg::MODE_ADD: state_in = lob_pkg::ST_FREE;
                  lob_pkg::MODE_CANCEL, lob_pkg::MODE_REMOVE: state_in = lob_pkg::ST_SRD;
                  lob_pkg::MODE_CLEAR: state_in = lob_pkg::ST_CLR;
                  lob_pkg::MODE_BEST, lob_pkg::MODE_VOLUME: state_in = lob_pkg::ST_LRD;
                  lob_pkg::MODE_DEPTH: begin
                     state_in = (lim_calc == '0) ? lob_pkg::ST_DFIN : lob_pkg::ST_LRD;
                  end
                  default: begin
                     res_in   = lob_pkg::rsp_plain(lob_pkg::STATUS_OK);
                     state_in = lob_pkg::ST_EMIT;
                  end
               endcase
            end
         end
         lob_pkg::ST_FREE: begin
            if (!slot_valid_ff[sidx_ff]) begin
               arrival_in = arrival_ff + 1'b1;
               refresh_in = 1'b1;
               sidx_in    = '0;
               state_in   = lob_pkg::ST_SRD;
            end else if (sidx_last) begin
               res_in   = lob_pkg::rsp_plain(lob_pkg::STATUS_FULL);
               state_in = lob_pkg::ST_EMIT;
            end else begin
               sidx_in = sidx_ff + 1'b1;
            end
         end
         lob_pkg::ST_SRD: begin
            state_in = lob_pkg::ST_SCHK;
         end
         lob_pkg::ST_SCHK: begin
            if (refresh_ff) begin
               cnt_in = cnt_acc;
               sum_in = sum_acc;
            end else if (mode_ff == lob_pkg::MODE_CANCEL) begin
               found_in = cand_found;
               best_in  = cand_best;
               if (better) begin
                  best_age_in = age;
               end
            end
            if (!sidx_last) begin
               sidx_in  = sidx_ff + 1'b1;
               state_in = lob_pkg::ST_SRD;
            end else if (refresh_ff || (mode_ff == lob_pkg::MODE_REMOVE)) begin
               res_in   = lob_pkg::rsp_plain(lob_pkg::STATUS_OK);
               state_in = lob_pkg::ST_EMIT;
            end else if (!cand_found) begin
               res_in   = lob_pkg::rsp_plain(lob_pkg::STATUS_NOT_FOUND);
               state_in = lob_pkg::ST_EMIT;
            end else begin
               refresh_in = 1'b1;
               sidx_in    = '0;
               state_in   = lob_pkg::ST_SRD;
            end
         end
         lob_pkg::ST_LRD: begin
            state_in = lob_pkg::ST_LCHK;
         end
         lob_pkg::ST_LCHK: begin
            lidx_in = lidx_ff + 1'b1;
            case (mode_ff)
               lob_pkg::MODE_VOLUME: begin
                  res_in   = lob_pkg::rsp_level(price_ff, lvl_hit ? lvl_rd_ff.sum : '0, 1'b1);
                  state_in = lob_pkg::ST_EMIT;
               end
               lob_pkg::MODE_BEST: begin
                  if (lvl_hit || lidx_last) begin
                     if (!phase_ff) begin
                        bid_v_in = lvl_hit;
                        bid_in   = lvl_hit ? scan_price : '0;
                        phase_in = 1'b1;
                        lidx_in  = '0;
                        state_in = lob_pkg::ST_LRD;
                     end else begin
                        res_in           = lob_pkg::rsp_plain(lob_pkg::STATUS_OK);
                        res_in.bid_valid = bid_v_ff;
                        res_in.top_bid   = bid_ff;
                        res_in.ask_valid = lvl_hit;
                        res_in.top_ask   = lvl_hit ? scan_price : '0;
                        res_in.mid_valid = bid_v_ff && lvl_hit;
                        res_in.mid_half_ticks = (bid_v_ff && lvl_hit)
                           ? {1'b0, bid_ff} + {1'b0, scan_price} : '0;
                        state_in = lob_pkg::ST_EMIT;
                     end
                  end else begin
                     state_in = lob_pkg::ST_LRD;
                  end
               end
               default: begin
                  if (lvl_qual) begin
                     n_in          = n_new;
                     pend_in       = 1'b1;
                     pend_price_in = scan_price;
                     pend_qty_in   = lvl_rd_ff.sum;
                     ret_in        = ((n_new == lim_ff) || lidx_last)
                                     ? lob_pkg::ST_DFIN : lob_pkg::ST_LRD;
                     if (pend_ff) begin
                        res_in   = lob_pkg::rsp_level(pend_price_ff, pend_qty_ff, 1'b0);
                        state_in = lob_pkg::ST_EMIT;
                     end else begin
                        state_in = ret_in;
                     end
                  end else begin
                     state_in = lidx_last ? lob_pkg::ST_DFIN : lob_pkg::ST_LRD;
                  end
               end
            endcase
         end
         lob_pkg::ST_DFIN: begin
            res_in   = pend_ff ? lob_pkg::rsp_level(pend_price_ff, pend_qty_ff, 1'b1)
                               : lob_pkg::rsp_plain(lob_pkg::STATUS_OK);
            ret_in   = lob_pkg::ST_IDLE;
            state_in = lob_pkg::ST_EMIT;
         end
         lob_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ret_ff;
            end
         end
         default: begin
            state_in = lob_pkg::ST_IDLE;
         end
      endcase
   end

   // memory and valid-bit controls
   always_comb begin
      slot_we    = 1'b0;
      slot_wdata = '{id: id_ff, side: side_ff, price: price_ff, qty: qty_ff,
                     arrival: arrival_ff};
      lvl_we     = 1'b0;
      lvl_waddr  = {side_ff, price_ff};
      lvl_wdata  = '0;
      v_set      = 1'b0;
      v_clr      = 1'b0;
      v_clr_idx  = sidx_ff;
      v_clr_all  = 1'b0;
      req_stall  = (state_ff != lob_pkg::ST_IDLE);
      case (state_ff)
         lob_pkg::ST_CLR: begin
            lvl_we    = 1'b1;
            lvl_waddr = lidx_ff;
         end
         lob_pkg::ST_IDLE: begin
            v_clr_all = req_valid && (lob_pkg::mode_type'(req_mode) == lob_pkg::MODE_CLEAR);
         end
         lob_pkg::ST_FREE: begin
            slot_we = !slot_valid_ff[sidx_ff];
            v_set   = !slot_valid_ff[sidx_ff];
         end
         lob_pkg::ST_SCHK: begin
            if (refresh_ff) begin
               lvl_we    = sidx_last;
               lvl_wdata = '{cnt: cnt_acc, sum: sum_acc};
            end else if (mode_ff == lob_pkg::MODE_REMOVE) begin
               v_clr  = match;
               lvl_we = sidx_last;
            end else begin
               v_clr     = sidx_last && cand_found;
               v_clr_idx = cand_best;
            end
         end
         default: begin
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lob_pkg::ST_CLR;
         ret_ff       <= lob_pkg::ST_IDLE;
         boot_ff      <= 1'b1;
         lidx_ff      <= '0;
         arrival_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         boot_ff      <= boot_in;
         lidx_ff      <= lidx_in;
         arrival_ff   <= arrival_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      id_ff         <= id_in;
      side_ff       <= side_in;
      price_ff      <= price_in;
      qty_ff        <= qty_in;
      lim_ff        <= lim_in;
      sidx_ff       <= sidx_in;
      refresh_ff    <= refresh_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_age_ff   <= best_age_in;
      cnt_ff        <= cnt_in;
      sum_ff        <= sum_in;
      n_ff          <= n_in;
      pend_ff       <= pend_in;
      pend_price_ff <= pend_price_in;
      pend_qty_ff   <= pend_qty_in;
      phase_ff      <= phase_in;
      bid_v_ff      <= bid_v_in;
      bid_ff        <= bid_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   // slot valid bits
   always_ff @(posedge clock) begin
      if (reset || v_clr_all) begin
         slot_valid_ff <= '0;
      end else begin
         if (v_set) begin
            slot_valid_ff[sidx_ff] <= 1'b1;
         end
         if (v_clr) begin
            slot_valid_ff[v_clr_idx] <= 1'b0;
         end
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[sidx_ff] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[sidx_ff];
   end

   // level memory
   always_ff @(posedge clock) begin
      if (lvl_we) begin
         lvl_mem[lvl_waddr] <= lvl_wdata;
      end
      lvl_rd_ff <= lvl_mem[lvl_raddr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_bid_valid      = rsp_ff.bid_valid;
   assign rsp_top_bid        = rsp_ff.top_bid;
   assign rsp_ask_valid      = rsp_ff.ask_valid;
   assign rsp_top_ask        = rsp_ff.top_ask;
   assign rsp_mid_valid      = rsp_ff.mid_valid;
   assign rsp_mid_half_ticks = rsp_ff.mid_half_ticks;
   assign rsp_level_valid    = rsp_ff.level_valid;
   assign rsp_level_price    = rsp_ff.level_price;
   assign rsp_level_qty      = rsp_ff.level_qty;
   assign rsp_last           = rsp_ff.last;

endmodule

FILE: sv/lob_checker.sv
// port-level checks of the limit order book and their bind
`include "limit_order_book_macros.svh"

module lob_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic        rsp_bid_valid,
   input logic        rsp_ask_valid,
   input logic        rsp_mid_valid,
   input logic        rsp_level_valid,
   input logic        rsp_last
);

   `LOB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `LOB_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `LOB_ASSERT_NOW(a_error_is_last, clock, reset, rsp_valid && rsp_status != lob_pkg::STATUS_OK, rsp_last)
   `LOB_ASSERT_NOW(a_mid_needs_sides, clock, reset, rsp_valid && rsp_mid_valid, rsp_bid_valid && rsp_ask_valid && !rsp_level_valid)

endmodule

bind limit_order_book lob_checker u_lob_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
   .rsp_bid_valid(rsp_bid_valid), .rsp_ask_valid(rsp_ask_valid),
   .rsp_mid_valid(rsp_mid_valid), .rsp_level_valid(rsp_level_valid), .rsp_last(rsp_last)
);

FILE: dv/limit_order_book_tb.sv
// self-checking testbench of the limit order book: directed table, a hold-off stall test, then random order flow
`timescale 1ns / 1ps

module limit_order_book_tb;

   localparam int STALL_LIMIT = 200000;
   localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   // request channel
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = '0;
   logic [63:0] req_order_id = '0;
   logic        req_side = 1'b0;
   logic [9:0]  req_price_tick = '0;
   logic [31:0] req_quantity = '0;
   logic [6:0]  req_max_levels = '0;

   // response channel
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_bid_valid;
   logic [9:0]  rsp_top_bid;
   logic        rsp_ask_valid;
   logic [9:0]  rsp_top_ask;
   logic        rsp_mid_valid;
   logic [10:0] rsp_mid_half_ticks;
   logic        rsp_level_valid;
   logic [9:0]  rsp_level_price;
   logic [39:0] rsp_level_qty;
   logic        rsp_last;

   limit_order_book u_top (.*);

   // one stimulus row; has_exp means a hand-typed answer follows
   typedef struct {
      lob_pkg::mode_type mode;
      logic [63:0]       id;
      logic              side;
      logic [9:0]        price;
      logic [31:0]       qty;
      logic [6:0]        levels;
      bit                has_exp;
      lob_pkg::rsp_type  exp;
   } row_type;

   // book mirror
   bit          bk_valid [lob_pkg::ORDER_SLOTS];
   logic [63:0] bk_id    [lob_pkg::ORDER_SLOTS];
   logic        bk_side  [lob_pkg::ORDER_SLOTS];
   logic [9:0]  bk_price [lob_pkg::ORDER_SLOTS];
   logic [31:0] bk_qty   [lob_pkg::ORDER_SLOTS];
   logic [31:0] bk_arr   [lob_pkg::ORDER_SLOTS];
   logic [31:0] bk_clock;
   int          lvl_cnt  [lob_pkg::LEVELS];
   logic [39:0] lvl_sum  [lob_pkg::LEVELS];

   lob_pkg::rsp_type expected_rsps[$];
   int      errors = 0;
   int      n_rsp = 0;
   int      n_full = 0;
   int      n_depth_rsp = 0;
   bit      hold_off = 1'b0;
   bit      hold_req = 1'b0;
   int      idle_cycles = 0;
   logic [63:0] live_ids[$];

   function automatic int lvl_of(logic s, logic [9:0] p);
      return int'(s) * lob_pkg::PRICE_TICKS + int'(p);
   endfunction

   // appends one answer to the outstanding list
   function automatic void queue_rsp(lob_pkg::rsp_type r);
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   function automatic void level_resum(logic s, logic [9:0] p);
      int c;
      logic [40:0] acc;
      c = 0;
      acc = '0;
      for (int i = 0; i < lob_pkg::ORDER_SLOTS; i++)
         if (bk_valid[i] && bk_side[i] == s && bk_price[i] == p) begin
            c++;
            acc = acc + bk_qty[i];
            if (acc > SUM_MAX) acc = SUM_MAX;
         end
      lvl_cnt[lvl_of(s, p)] = c;
      lvl_sum[lvl_of(s, p)] = acc[39:0];
   endfunction

   // applies one transaction to the mirror and queues the answers
   function automatic void book_apply(lob_pkg::mode_type m, logic [63:0] id, logic s,
                                      logic [9:0] p, logic [31:0] q, logic [6:0] ml);
      lob_pkg::rsp_type r;
      int pick;
      int lim;
      int n;
      int pr;
      logic [31:0] age, best_age;
      bit bv, av;
      r = '0;
      r.last = 1'b1;
      case (m)
         lob_pkg::MODE_ADD: begin
            pick = -1;
            for (int i = 0; i < lob_pkg::ORDER_SLOTS && pick < 0; i++)
               if (!bk_valid[i]) pick = i;
            if (pick < 0) begin
               r.status = lob_pkg::STATUS_FULL;
               n_full++;
            end else begin
               bk_valid[pick] = 1'b1; bk_id[pick] = id; bk_side[pick] = s;
               bk_price[pick] = p; bk_qty[pick] = q; bk_arr[pick] = bk_clock;
               bk_clock = bk_clock + 1;
               level_resum(s, p);
            end
            queue_rsp(r);
         end
         lob_pkg::MODE_CANCEL: begin
            pick = -1;
            best_age = '0;
            for (int i = 0; i < lob_pkg::ORDER_SLOTS; i++)
               if (bk_valid[i] && bk_side[i] == s && bk_price[i] == p && bk_id[i] == id) begin
                  age = bk_clock - bk_arr[i];
                  if (pick < 0 || age > best_age) begin
                     pick = i;
                     best_age = age;
                  end
               end
            if (pick < 0) r.status = lob_pkg::STATUS_NOT_FOUND;
            else begin
               bk_valid[pick] = 1'b0;
               level_resum(s, p);
            end
            queue_rsp(r);
         end
         lob_pkg::MODE_REMOVE: begin
            for (int i = 0; i < lob_pkg::ORDER_SLOTS; i++)
               if (bk_valid[i] && bk_side[i] == s && bk_price[i] == p) bk_valid[i] = 1'b0;
            lvl_cnt[lvl_of(s, p)] = 0;
            lvl_sum[lvl_of(s, p)] = '0;
            queue_rsp(r);
         end
         lob_pkg::MODE_CLEAR: begin
            for (int i = 0; i < lob_pkg::ORDER_SLOTS; i++) bk_valid[i] = 1'b0;
            for (int i = 0; i < lob_pkg::LEVELS; i++) begin
               lvl_cnt[i] = 0;
               lvl_sum[i] = '0;
            end
            queue_rsp(r);
         end
         lob_pkg::MODE_BEST: begin
            bv = 1'b0;
            av = 1'b0;
            for (int i = lob_pkg::PRICE_TICKS - 1; i >= 0 && !bv; i--)
               if (lvl_cnt[i] != 0) begin
                  bv = 1'b1;
                  r.top_bid = i[9:0];
               end
            for (int i = 0; i < lob_pkg::PRICE_TICKS && !av; i++)
               if (lvl_cnt[lob_pkg::PRICE_TICKS + i] != 0) begin
                  av = 1'b1;
                  r.top_ask = i[9:0];
               end
            r.bid_valid = bv;
            r.ask_valid = av;
            r.mid_valid = bv && av;
            if (bv && av) r.mid_half_ticks = {1'b0, r.top_bid} + {1'b0, r.top_ask};
            queue_rsp(r);
         end
         lob_pkg::MODE_DEPTH: begin
            lim = (int'(ml) > lob_pkg::MAX_DEPTH) ? lob_pkg::MAX_DEPTH : int'(ml);
            n = 0;
            for (int i = 0; i < lob_pkg::PRICE_TICKS && n < lim; i++) begin
               pr = s ? i : lob_pkg::PRICE_TICKS - 1 - i;
               if (lvl_cnt[lvl_of(s, pr[9:0])] != 0 && lvl_sum[lvl_of(s, pr[9:0])] != 0) begin
                  r = '0;
                  r.level_valid = 1'b1;
                  r.level_price = pr[9:0];
                  r.level_qty = lvl_sum[lvl_of(s, pr[9:0])];
                  queue_rsp(r);
                  n++;
               end
            end
            // empty scan still answers once
            if (n == 0) begin
               r = '0;
               r.last = 1'b1;
               queue_rsp(r);
            end else
               expected_rsps[$].last = 1'b1;
         end
         lob_pkg::MODE_VOLUME: begin
            r.level_valid = 1'b1;
            r.level_price = p;
            r.level_qty = lvl_cnt[lvl_of(s, p)] != 0 ? lvl_sum[lvl_of(s, p)] : '0;
            queue_rsp(r);
         end
         default: queue_rsp(r);
      endcase
   endfunction

   // one request transaction; mirror updated at acceptance
   task automatic send(lob_pkg::mode_type m, logic [63:0] id, logic s, logic [9:0] p,
                       logic [31:0] q, logic [6:0] ml);
      req_valid <= 1'b1;
      req_mode <= m;
      req_order_id <= id;
      req_side <= s;
      req_price_tick <= p;
      req_quantity <= q;
      req_max_levels <= ml;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book_apply(m, id, s, p, q, ml);
      if (m == lob_pkg::MODE_ADD) live_ids.insert(live_ids.size(), id);
   endtask

   task automatic gap(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      lob_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_rsp++;
         if (expected_rsps.size() == 0) begin
            $error("response with nothing outstanding");
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (want.level_valid && !want.last) n_depth_rsp++;
            if (rsp_status !== want.status) begin
               $error("status exp %0d got %0d", want.status, rsp_status); errors++;
            end
            if (rsp_bid_valid !== want.bid_valid) begin
               $error("bid_valid exp %0d got %0d", want.bid_valid, rsp_bid_valid); errors++;
            end
            if (rsp_top_bid !== want.top_bid) begin
               $error("top_bid exp %0d got %0d", want.top_bid, rsp_top_bid); errors++;
            end
            if (rsp_ask_valid !== want.ask_valid) begin
               $error("ask_valid exp %0d got %0d", want.ask_valid, rsp_ask_valid); errors++;
            end
            if (rsp_top_ask !== want.top_ask) begin
               $error("top_ask exp %0d got %0d", want.top_ask, rsp_top_ask); errors++;
            end
            if (rsp_mid_valid !== want.mid_valid) begin
               $error("mid_valid exp %0d got %0d", want.mid_valid, rsp_mid_valid); errors++;
            end
            if (rsp_mid_half_ticks !== want.mid_half_ticks) begin
               $error("mid_half_ticks exp %0d got %0d", want.mid_half_ticks,
                      rsp_mid_half_ticks);
               errors++;
            end
            if (rsp_level_valid !== want.level_valid) begin
               $error("level_valid exp %0d got %0d", want.level_valid, rsp_level_valid);
               errors++;
            end
            if (rsp_level_price !== want.level_price) begin
               $error("level_price exp %0d got %0d", want.level_price, rsp_level_price);
               errors++;
            end
            if (rsp_level_qty !== want.level_qty) begin
               $error("level_qty exp %0h got %0h", want.level_qty, rsp_level_qty); errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last exp %0d got %0d", want.last, rsp_last); errors++;
            end
         end
      end
   end

   // receiver stall pattern; a long hold-off overrides it
   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else if ($urandom_range(0, 3) == 0) rsp_stall <= ($urandom_range(0, 1) == 1);
   end

   // watchdog on cycles with no accepted transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // hold-off long enough for the block to fill and stall its input
   initial begin
      int held;
      wait (hold_req);
      hold_off = 1'b1;
      held = 0;
      while (held < 3000) begin
         @(posedge clock);
         held++;
      end
      hold_off = 1'b0;
   end

   row_type rows[$];

   function automatic row_type mk(lob_pkg::mode_type m, logic [63:0] id, logic s,
                                  logic [9:0] p, logic [31:0] q, logic [6:0] ml);
      row_type r;
      r.mode = m; r.id = id; r.side = s; r.price = p; r.qty = q; r.levels = ml;
      r.has_exp = 1'b0; r.exp = '0;
      return r;
   endfunction

   function automatic row_type mk_exp(lob_pkg::mode_type m, logic [63:0] id, logic s,
                                      logic [9:0] p, logic [31:0] q, logic [6:0] ml,
                                      lob_pkg::rsp_type e);
      row_type r;
      r = mk(m, id, s, p, q, ml);
      r.has_exp = 1'b1;
      r.exp = e;
      return r;
   endfunction

   initial begin
      lob_pkg::rsp_type e;
      int burst;
      int pick;
      int kind;
      logic [63:0] id;
      logic [9:0] p;
      bk_clock = '0;
      for (int i = 0; i < lob_pkg::ORDER_SLOTS; i++) bk_valid[i] = 1'b0;
      for (int i = 0; i < lob_pkg::LEVELS; i++) begin
         lvl_cnt[i] = 0;
         lvl_sum[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table: empty book, extremes, the not-found code
      e = '0; e.last = 1'b1;
      rows.insert(rows.size(), mk_exp(lob_pkg::MODE_BEST, '0, 1'b0, '0, '0, '0, e));
      rows.insert(rows.size(), mk_exp(lob_pkg::MODE_DEPTH, '0, 1'b0, '0, '0, 7'd64, e));
      e.status = lob_pkg::STATUS_NOT_FOUND;
      rows.insert(rows.size(), mk_exp(lob_pkg::MODE_CANCEL, '1, 1'b1, 10'h3FF, '0, '0, e));
      e = '0; e.last = 1'b1;
      rows.insert(rows.size(), mk_exp(lob_pkg::MODE_ADD, '1, 1'b0, 10'h3FF, '1, '0, e));
      rows.insert(rows.size(), mk_exp(lob_pkg::MODE_ADD, '0, 1'b1, 10'h000, '1, '0, e));
      rows.insert(rows.size(), mk(lob_pkg::MODE_ADD, 64'd5, 1'b0, 10'h3FF, '1, '0));
      rows.insert(rows.size(), mk(lob_pkg::MODE_ADD, 64'd5, 1'b0, 10'h3FF, 32'd7, '0));
      rows.insert(rows.size(), mk(lob_pkg::MODE_ADD, 64'd9, 1'b1, 10'd500, 32'd0, '0));
      rows.insert(rows.size(), mk(lob_pkg::MODE_BEST, '0, 1'b0, '0, '0, '0));
      rows.insert(rows.size(), mk(lob_pkg::MODE_VOLUME, '0, 1'b0, 10'h3FF, '0, '0));
      rows.insert(rows.size(), mk(lob_pkg::MODE_VOLUME, '0, 1'b1, 10'd500, '0, '0));
      rows.insert(rows.size(), mk(lob_pkg::MODE_VOLUME, '0, 1'b1, 10'd501, '0, '0));
      rows.insert(rows.size(), mk(lob_pkg::MODE_DEPTH, '0, 1'b1, '0, '0, 7'd127));
      rows.insert(rows.size(), mk(lob_pkg::MODE_DEPTH, '0, 1'b0, '0, '0, 7'd0));
      rows.insert(rows.size(), mk(lob_pkg::MODE_CANCEL, 64'd5, 1'b0, 10'h3FF, '0, '0));
      rows.insert(rows.size(), mk(lob_pkg::MODE_VOLUME, '0, 1'b0, 10'h3FF, '0, '0));
      rows.insert(rows.size(), mk(lob_pkg::MODE_NONE, '1, 1'b1, '1, '1, '1));
      rows.insert(rows.size(), mk(lob_pkg::MODE_REMOVE, '0, 1'b0, 10'h3FF, '0, '0));
      rows.insert(rows.size(), mk(lob_pkg::MODE_REMOVE, '0, 1'b0, 10'd3, '0, '0));
      rows.insert(rows.size(), mk(lob_pkg::MODE_BEST, '0, 1'b0, '0, '0, '0));
      rows.insert(rows.size(), mk(lob_pkg::MODE_CLEAR, '0, 1'b0, '0, '0, '0));
      rows.insert(rows.size(), mk_exp(lob_pkg::MODE_BEST, '0, 1'b0, '0, '0, '0, e));

      foreach (rows[i]) begin
         send(rows[i].mode, rows[i].id, rows[i].side, rows[i].price, rows[i].qty,
              rows[i].levels);
         // typed answer must agree with the mirror's
         if (rows[i].has_exp && expected_rsps[$] != rows[i].exp) begin
            $error("row %0d: table exp %p mirror %p", i, rows[i].exp, expected_rsps[$]);
            errors++;
         end
      end
      drain();

      // receiver holds off while the sender keeps offering, so the input stalls
      hold_req = 1'b1;
      for (int i = 0; i < 4; i++)
         send(lob_pkg::MODE_VOLUME, '0, 1'b0, 10'(i), '0, '0);
      drain();

      // random flow: mostly adds and cancels of live ids near a mid price
      for (int it = 0; it < 74; ) begin
         burst = $urandom_range(1, 8);
         for (int b = 0; b < burst; b++, it++) begin
            kind = $urandom_range(0, 99);
            p = 10'd500 + 10'($urandom_range(0, 15));
            if ($urandom_range(0, 9) == 0) p = 10'($urandom);
            if (kind < 40)
               send(lob_pkg::MODE_ADD,
                    ($urandom_range(0, 3) == 0) ? 64'd42 : {$urandom, $urandom},
                    1'($urandom_range(0, 1)), p,
                    ($urandom_range(0, 4) == 0) ? 32'($urandom_range(0, 1)) : $urandom,
                    '0);
            else if (kind < 60 && live_ids.size() > 0) begin
               pick = $urandom_range(0, live_ids.size() - 1);
               id = live_ids[pick];
               send(lob_pkg::MODE_CANCEL, id, 1'($urandom_range(0, 1)), p, '0, '0);
            end else if (kind < 64)
               send(lob_pkg::MODE_REMOVE, '0, 1'($urandom_range(0, 1)), p, '0, '0);
            else if (kind < 66)
               send(lob_pkg::MODE_CLEAR, {$urandom, $urandom}, 1'b0, '0, '0, '0);
            else if (kind < 76) send(lob_pkg::MODE_BEST, '0, 1'b0, '0, '0, '0);
            else if (kind < 88)
               send(lob_pkg::MODE_DEPTH, '0, 1'($urandom_range(0, 1)), '0, '0,
                    7'($urandom_range(0, 127)));
            else if (kind < 98)
               send(lob_pkg::MODE_VOLUME, '0, 1'($urandom_range(0, 1)), p, '0, '0);
            else
               send(lob_pkg::MODE_NONE, {$urandom, $urandom}, 1'b1, p, $urandom,
                    7'($urandom));
         end
         if (it > 30 && it < 40) drain();
         else gap($urandom_range(0, 600));
      end
      drain();
      repeat (5000) @(posedge clock);

      $display("covered %0d responses, %0d depth levels, %0d store-full answers",
               n_rsp, n_depth_rsp, n_full);
      if (errors == 0 && expected_rsps.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

FILE: limit_order_book.f
+incdir+sv
sv/lob_pkg.sv
sv/limit_order_book.sv
sv/lob_checker.sv
dv/limit_order_book_tb.sv
